@@ rtl/rlsw_pkg.sv @@
// ----------------------------------------------------------------------------
// rlsw_pkg
// Shared types and constants of the single-wire RGB LED waveform generator.
// ----------------------------------------------------------------------------
package rlsw_pkg;

  localparam int RLSW_QUEUE_DEPTH = 4;
  localparam int RLSW_ADDR_W      = 5;
  localparam int RLSW_DATA_W      = 32;
  localparam int RLSW_PULSE_W     = 12;
  localparam int RLSW_LATCH_W     = 20;
  localparam int RLSW_BITS_PER_PX = 24;

  typedef logic [1:0] op_t;

  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_PIXEL = 2'd1;
  localparam op_t OP_LATCH = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd0;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd1;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [2:0] REG_ONE_LOW    = 3'd3;
  localparam logic [2:0] REG_LATCH      = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd5;

  typedef struct packed {
    logic [RLSW_PULSE_W-1:0] zero_high;
    logic [RLSW_PULSE_W-1:0] zero_low;
    logic [RLSW_PULSE_W-1:0] one_high;
    logic [RLSW_PULSE_W-1:0] one_low;
    logic [RLSW_LATCH_W-1:0] latch;
  } timing_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    op_t                         op;
    logic [RLSW_BITS_PER_PX-1:0] pix;
  } entry_t;

endpackage

@@ rtl/rlsw_if.sv @@
// ----------------------------------------------------------------------------
// rlsw_if
// Valid/ready channels for requests and results of the LED waveform block.
// ----------------------------------------------------------------------------
interface rlsw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, op, red, green, blue, input ready);
  modport sink (input valid, op, red, green, blue, output ready);
endinterface

interface rlsw_out_if;
  logic valid;
  logic ready;
  logic line;
  logic busy_res;
  logic refused;

  modport source (output valid, line, busy_res, refused, input ready);
  modport sink (input valid, line, busy_res, refused, output ready);
endinterface

@@ rtl/rlsw_front.sv @@
// ----------------------------------------------------------------------------
// rlsw_front
// Takes requests, scales the pixel channels by the brightness and hands
// classified entries to the queue.
// ----------------------------------------------------------------------------
module rlsw_front
  import rlsw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    brightness,
  rlsw_in_if.sink       req,
  input  logic          q_full,
  output logic          q_push,
  output entry_t        q_data
);

  logic        st_valid;
  op_t         st_op;
  logic [15:0] st_prod_g;
  logic [15:0] st_prod_r;
  logic [15:0] st_prod_b;
  logic        take;

  // Exact floor(x / 255) for any 16-bit x up to 65279.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  assign req.ready = !st_valid || !q_full;
  assign take      = req.valid && req.ready;
  assign q_push    = st_valid && !q_full;

  assign q_data.op  = st_op;
  assign q_data.pix = {div255(st_prod_g), div255(st_prod_r), div255(st_prod_b)};

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (take) begin
      st_valid <= 1'b1;
    end else if (q_push) begin
      st_valid <= 1'b0;
    end
    if (take) begin
      st_op     <= req.op;
      st_prod_g <= brightness * req.green;
      st_prod_r <= brightness * req.red;
      st_prod_b <= brightness * req.blue;
    end
  end

endmodule

@@ rtl/rlsw_queue.sv @@
// ----------------------------------------------------------------------------
// rlsw_queue
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module rlsw_queue
  import rlsw_pkg::*;
#(
  parameter int Depth = RLSW_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/rlsw_back.sv @@
// ----------------------------------------------------------------------------
// rlsw_back
// Waveform engine: runs the bit and latch phases one request at a time and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module rlsw_back
  import rlsw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  timing_t  timing,
  input  logic     q_valid,
  input  entry_t   q_data,
  output logic     q_pop,
  rlsw_out_if.source res
);

  typedef enum logic [1:0] {PH_IDLE, PH_HIGH, PH_LOW, PH_LATCH} phase_t;

  localparam int CntW = $clog2(RLSW_BITS_PER_PX + 1);

  phase_t                       wave_phase, wave_phase_next;
  logic [RLSW_BITS_PER_PX-1:0]  bit_shifter, bit_shifter_next;
  logic [CntW-1:0]              bits_remaining, bits_remaining_next;
  logic [RLSW_LATCH_W-1:0]      phase_ticks_left, phase_ticks_left_next;
  logic                         out_valid;
  logic                         line, line_next;
  logic                         busy_res;
  logic                         refused, refused_next;
  logic [RLSW_LATCH_W-1:0]      ticks_dec;
  logic [RLSW_BITS_PER_PX-1:0]  shifted;
  logic [CntW-1:0]              bits_dec;

  // A programmed count of zero behaves as one tick.
  function automatic logic [RLSW_LATCH_W-1:0] pulse_len(input logic [RLSW_PULSE_W-1:0] t);
    return (t == '0) ? RLSW_LATCH_W'(1) : RLSW_LATCH_W'(t);
  endfunction

  assign q_pop        = q_valid && (!out_valid || res.ready);
  assign res.valid    = out_valid;
  assign res.line     = line;
  assign res.busy_res = busy_res;
  assign res.refused  = refused;

  assign ticks_dec = (phase_ticks_left == '0) ? '0 : phase_ticks_left - 1'b1;
  assign shifted   = {bit_shifter[RLSW_BITS_PER_PX-2:0], 1'b0};
  assign bits_dec  = (bits_remaining == '0) ? '0 : bits_remaining - 1'b1;

  always_comb begin
    wave_phase_next       = wave_phase;
    bit_shifter_next      = bit_shifter;
    bits_remaining_next   = bits_remaining;
    phase_ticks_left_next = phase_ticks_left;
    line_next             = 1'b0;
    refused_next          = 1'b0;
    case (q_data.op)
      OP_PIXEL, OP_LATCH: begin
        if (wave_phase != PH_IDLE) begin
          refused_next = 1'b1;
        end else if (q_data.op == OP_PIXEL) begin
          bit_shifter_next      = q_data.pix;
          bits_remaining_next   = CntW'(RLSW_BITS_PER_PX);
          wave_phase_next       = PH_HIGH;
          phase_ticks_left_next = q_data.pix[RLSW_BITS_PER_PX-1] ?
                                  pulse_len(timing.one_high) : pulse_len(timing.zero_high);
        end else begin
          wave_phase_next       = PH_LATCH;
          phase_ticks_left_next = (timing.latch == '0) ? RLSW_LATCH_W'(1) : timing.latch;
        end
      end
      OP_TICK: begin
        if (wave_phase != PH_IDLE) begin
          line_next             = (wave_phase == PH_HIGH);
          phase_ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            case (wave_phase)
              PH_HIGH: begin
                wave_phase_next       = PH_LOW;
                phase_ticks_left_next = bit_shifter[RLSW_BITS_PER_PX-1] ?
                                        pulse_len(timing.one_low) : pulse_len(timing.zero_low);
              end
              PH_LOW: begin
                bit_shifter_next    = shifted;
                bits_remaining_next = bits_dec;
                if (bits_dec != '0) begin
                  wave_phase_next       = PH_HIGH;
                  phase_ticks_left_next = shifted[RLSW_BITS_PER_PX-1] ?
                                          pulse_len(timing.one_high) :
                                          pulse_len(timing.zero_high);
                end else begin
                  wave_phase_next = PH_IDLE;
                end
              end
              default: begin
                wave_phase_next = PH_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_phase       <= PH_IDLE;
      bit_shifter      <= '0;
      bits_remaining   <= '0;
      phase_ticks_left <= '0;
      out_valid        <= 1'b0;
      line             <= 1'b0;
      busy_res         <= 1'b0;
      refused          <= 1'b0;
    end else begin
      if (q_pop) begin
        wave_phase       <= wave_phase_next;
        bit_shifter      <= bit_shifter_next;
        bits_remaining   <= bits_remaining_next;
        phase_ticks_left <= phase_ticks_left_next;
        out_valid        <= 1'b1;
        line             <= line_next;
        busy_res         <= (wave_phase_next != PH_IDLE);
        refused          <= refused_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/rgb_led_serial_waveform.sv @@
// ----------------------------------------------------------------------------
// rgb_led_serial_waveform
// Single-wire RGB LED waveform generator with an APB-style register port.
// ----------------------------------------------------------------------------
// Every request returns exactly one result. The block sustains one request
// per clock while the result side does not stall. The input stage with the
// brightness multipliers is loaded when a request is taken; the queue entry
// is written from that stage and the result register from the queue entry,
// which waits while the result side stalls. The rate is set by the waveform
// engine, which completes one request per cycle into its result register
// while the result side is ready. A pixel is scaled by brightness, then sent
// green, red, blue, most significant bit first, each bit a high pulse and a
// low pulse advanced one tick per tick request. Pixel or latch requests that
// arrive while a waveform is running are dropped and flagged as refused.
// Registers sit at byte offsets 0, 4, 8, 12, 16 and 20 and should be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_serial_waveform
  import rlsw_pkg::*;
#(
  parameter int QueueDepth = RLSW_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RLSW_ADDR_W-1:0] paddr,
  input  logic [RLSW_DATA_W-1:0] pwdata,
  output logic [RLSW_DATA_W-1:0] prdata,
  output logic                   pready,
  rlsw_in_if.sink                req,
  rlsw_out_if.source             res
);

  timing_t    timing;
  logic [7:0] brightness;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  entry_t     q_wr;
  entry_t     q_rd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.zero_high <= RLSW_PULSE_W'(6);
      timing.zero_low  <= RLSW_PULSE_W'(13);
      timing.one_high  <= RLSW_PULSE_W'(11);
      timing.one_low   <= RLSW_PULSE_W'(10);
      timing.latch     <= RLSW_LATCH_W'(800);
      brightness       <= 8'd255;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ZERO_HIGH:  timing.zero_high <= pwdata[RLSW_PULSE_W-1:0];
        REG_ZERO_LOW:   timing.zero_low  <= pwdata[RLSW_PULSE_W-1:0];
        REG_ONE_HIGH:   timing.one_high  <= pwdata[RLSW_PULSE_W-1:0];
        REG_ONE_LOW:    timing.one_low   <= pwdata[RLSW_PULSE_W-1:0];
        REG_LATCH:      timing.latch     <= pwdata[RLSW_LATCH_W-1:0];
        REG_BRIGHTNESS: brightness       <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ZERO_HIGH:  prdata = RLSW_DATA_W'(timing.zero_high);
      REG_ZERO_LOW:   prdata = RLSW_DATA_W'(timing.zero_low);
      REG_ONE_HIGH:   prdata = RLSW_DATA_W'(timing.one_high);
      REG_ONE_LOW:    prdata = RLSW_DATA_W'(timing.one_low);
      REG_LATCH:      prdata = RLSW_DATA_W'(timing.latch);
      REG_BRIGHTNESS: prdata = RLSW_DATA_W'(brightness);
      default:        prdata = '0;
    endcase
  end

  rlsw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .brightness (brightness),
    .req        (req),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr)
  );

  rlsw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_rd)
  );

  rlsw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .timing  (timing),
    .q_valid (q_valid),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
